// ===== hw/rtl/sli_pkg.sv =====
package sli_pkg;

    // list geometry
    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [VAL_W-1:0]  value;
    } cell_ctl_t;

    // what a cell shows its neighbours and the top level
    typedef struct packed {
        logic              valid;
        logic [VAL_W-1:0]  value;
        logic              ge;
        logic              hit;
        logic [VAL_W-1:0]  value_next;
    } cell_tap_t;

endpackage

// ===== hw/rtl/sli_if.sv =====
interface sli_cmd_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [sli_pkg::VAL_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sli_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [sli_pkg::OCC_W-1:0] occupancy;
    logic [sli_pkg::VAL_W-1:0] smallest;
    logic                      smallest_valid;

    modport source (output valid, output status, output occupancy, output smallest,
                    output smallest_valid, input ready);
    modport sink   (input valid, input status, input occupancy, input smallest,
                    input smallest_valid, output ready);
endinterface

// ===== hw/rtl/sli_cell.sv =====
module sli_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sli_pkg::cell_ctl_t ctl,
    input  sli_pkg::cell_tap_t left,
    input  sli_pkg::cell_tap_t right,
    output sli_pkg::cell_tap_t tap
);
    import sli_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             ge;

    // empty slots count as greater than anything, so ge is a monotone mask
    assign ge = !valid_reg || ($signed(value_reg) >= $signed(ctl.value));

    // shift right on insert, shift left on remove, from the boundary onwards
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.ins)
        begin
            valid_next = valid_reg || left.valid;
            if (ge)
            begin
                value_next = left.ge ? left.value : ctl.value;
            end
        end
        else if (ctl.rem && ge)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // hit: first slot not below the value, and equal to it
    assign tap.valid      = valid_reg;
    assign tap.value      = value_reg;
    assign tap.ge         = ge;
    assign tap.hit        = valid_reg && !left.ge && (value_reg == ctl.value);
    assign tap.value_next = value_next;

endmodule

// ===== hw/rtl/sorted_list_insert_remove_unit.sv =====
// Sorted list of up to CAPACITY signed 32-bit values held in a row of cells,
// one value per cell, kept ascending and packed from cell 0. Every cell compares
// its own value with the request in the same cycle and takes its new value from
// itself or a neighbour, so one request is accepted per clock cycle while results
// are taken; a result is registered in the cycle after acceptance, and a new
// request is taken while that result waits if it is taken in the same cycle.
// Inserts go in front of equal entries and are dropped when the list is full;
// a remove takes the first equal entry. The list is empty after reset.
module sorted_list_insert_remove_unit (
    input  logic      clk,
    input  logic      rst_n,
    sli_cmd_if.sink   cmd,
    sli_rsp_if.source rsp
);
    import sli_pkg::*;

    cell_ctl_t        ctl;
    cell_tap_t        taps [CAPACITY];
    cell_tap_t        left_edge;
    cell_tap_t        right_edge;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] valid_vec;
    logic             accept;
    logic             full;
    logic             found;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          status_next;

    logic             rsp_valid_reg;
    status_t          status_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [VAL_W-1:0] smallest_reg;
    logic             smallest_valid_reg;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !rsp_valid_reg || rsp.ready;

    // edges of the row: nothing before cell 0 is ever ge, nothing past the end
    assign left_edge  = '{valid: 1'b1, value: '0, ge: 1'b0, hit: 1'b0, value_next: '0};
    assign right_edge = '{valid: 1'b0, value: '0, ge: 1'b1, hit: 1'b0, value_next: '0};

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_vec[i]   = taps[i].hit;
            valid_vec[i] = taps[i].valid;
        end
    end

    assign full  = taps[CAPACITY-1].valid;
    assign found = |hit_vec;

    assign ctl.value = cmd.value;
    assign ctl.ins   = accept && (kind_t'(cmd.kind) == KIND_INSERT) && !full;
    assign ctl.rem   = accept && (kind_t'(cmd.kind) == KIND_REMOVE) && found;

    // the row of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        sli_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .left  ((g == 0) ? left_edge : taps[(g == 0) ? 0 : g - 1]),
            .right ((g == CAPACITY - 1) ? right_edge
                                        : taps[(g == CAPACITY - 1) ? g : g + 1]),
            .tap   (taps[g])
        );
    end

    // status and occupancy
    always_comb
    begin
        count_next = count_reg;
        if (kind_t'(cmd.kind) == KIND_INSERT)
        begin
            status_next = full ? ST_FULL : ST_INSERTED;
        end
        else
        begin
            status_next = found ? ST_REMOVED : ST_NOT_FOUND;
        end
        if (ctl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg         <= status_next;
            occ_reg            <= OCC_W'(count_next);
            smallest_valid_reg <= (count_next != '0);
            smallest_reg       <= (count_next != '0) ? taps[0].value_next : '0;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.occupancy      = occ_reg;
    assign rsp.smallest       = smallest_reg;
    assign rsp.smallest_valid = smallest_valid_reg;

    // occupied cells form a prefix and match the count
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("occupied cells are not a prefix");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("count disagrees with occupied cells");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        taps[1].valid |-> ($signed(taps[0].value) <= $signed(taps[1].value)))
        else $error("head entries out of order");

    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list");

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one boundary hit");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import sli_pkg::*;

    localparam logic [VAL_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
    localparam int N_RANDOM = 700;
    localparam int POOL_SIZE = 10;
    localparam int PHASE_LEN = 60;
    localparam int IDLE_PCT = 7;

    typedef struct {
        kind_t            kind;
        logic [VAL_W-1:0] value;
    } list_req_t;

    typedef struct {
        status_t          status;
        logic [OCC_W-1:0] occupancy;
        logic [VAL_W-1:0] smallest;
        logic             smallest_valid;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    sli_cmd_if cmd_bus ();
    sli_rsp_if rsp_bus ();

    sorted_list_insert_remove_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // requests still to be driven, and results still owed by the block
    list_req_t               pending_reqs[$];
    list_rsp_t               owed_rsps[$];
    // shadow copy of the sorted list, ascending
    logic signed [VAL_W-1:0] shadow_list[$];

    int  errors;
    int  reqs_taken;
    int  rsps_checked;
    int  status_seen[4];
    int  peak_occupancy;
    logic cmd_fire;
    logic calm;
    list_req_t next_req;
    list_rsp_t got_rsp;

    // no idling on either side over a stretch in the middle of the run
    assign calm = (reqs_taken >= 250) && (reqs_taken < 400);

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // apply one request to the shadow list and return the result it gives
    function automatic list_rsp_t apply_request(kind_t kind, logic signed [VAL_W-1:0] value);
        list_rsp_t r;
        int pos;
        pos = 0;
        if (kind == KIND_INSERT) begin
            if (shadow_list.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                while (pos < shadow_list.size() && shadow_list[pos] < value)
                    pos++;
                shadow_list.insert(pos, value);
                r.status = ST_INSERTED;
            end
        end
        else begin
            while (pos < shadow_list.size() && shadow_list[pos] != value)
                pos++;
            if (pos >= shadow_list.size()) begin
                r.status = ST_NOT_FOUND;
            end
            else begin
                shadow_list.delete(pos);
                r.status = ST_REMOVED;
            end
        end
        r.occupancy      = OCC_W'(shadow_list.size());
        r.smallest_valid = (shadow_list.size() != 0);
        r.smallest       = r.smallest_valid ? shadow_list[0] : '0;
        status_seen[r.status]++;
        if (shadow_list.size() > peak_occupancy)
            peak_occupancy = shadow_list.size();
        return r;
    endfunction

    task automatic queue_req(kind_t kind, logic [VAL_W-1:0] value);
        list_req_t q;
        q.kind  = kind;
        q.value = value;
        pending_reqs.push_back(q);
    endtask

    // request driver and result sink, both change on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            cmd_bus.valid <= 1'b0;
            rsp_bus.ready <= 1'b0;
        end
        else begin
            if (!cmd_bus.valid || cmd_fire) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_req = pending_reqs.pop_front();
                    cmd_bus.valid <= 1'b1;
                    cmd_bus.kind  <= next_req.kind;
                    cmd_bus.value <= next_req.value;
                end
                else begin
                    // idle: payload is noise
                    cmd_bus.valid <= 1'b0;
                    cmd_bus.kind  <= 1'($urandom_range(1));
                    cmd_bus.value <= $urandom;
                end
            end
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: check results against the oldest owed one, predict new requests
    always @(posedge clk) begin
        cmd_fire = rst_n && cmd_bus.valid && cmd_bus.ready;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (owed_rsps.size() == 0) begin
                $display("%0t: unexpected result status=%0d occupancy=%0d smallest=%h",
                         $time, rsp_bus.status, rsp_bus.occupancy, rsp_bus.smallest);
                errors++;
            end
            else begin
                got_rsp = owed_rsps.pop_front();
                rsps_checked++;
                if (rsp_bus.status !== got_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, got_rsp.status, rsp_bus.status);
                    errors++;
                end
                if (rsp_bus.occupancy !== got_rsp.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, got_rsp.occupancy, rsp_bus.occupancy);
                    errors++;
                end
                if (rsp_bus.smallest !== got_rsp.smallest) begin
                    $display("%0t: smallest expected %h actual %h",
                             $time, got_rsp.smallest, rsp_bus.smallest);
                    errors++;
                end
                if (rsp_bus.smallest_valid !== got_rsp.smallest_valid) begin
                    $display("%0t: smallest_valid expected %0d actual %0d",
                             $time, got_rsp.smallest_valid, rsp_bus.smallest_valid);
                    errors++;
                end
            end
        end
        if (cmd_fire) begin
            owed_rsps.push_back(apply_request(kind_t'(cmd_bus.kind), cmd_bus.value));
            reqs_taken++;
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [VAL_W-1:0] pool[POOL_SIZE];
        int insert_pct;
        int roll;
        kind_t kind;

        errors         = 0;
        reqs_taken     = 0;
        rsps_checked   = 0;
        peak_occupancy = 0;
        cmd_fire       = 1'b0;
        for (int s = 0; s < 4; s++)
            status_seen[s] = 0;
        cmd_bus.valid = 1'b0;
        cmd_bus.kind  = 1'b0;
        cmd_bus.value = '0;
        rsp_bus.ready = 1'b0;
        rst_n         = 1'b0;

        // directed: remove from empty, fill with extremes and duplicates,
        // insert into a full list, then remove extremes, a duplicate and a missing value
        queue_req(KIND_REMOVE, INT_MAX);
        queue_req(KIND_INSERT, 32'd0);
        queue_req(KIND_INSERT, 32'd0);
        queue_req(KIND_INSERT, INT_MAX);
        queue_req(KIND_INSERT, INT_MIN);
        queue_req(KIND_INSERT, 32'hFFFF_FFFF);
        queue_req(KIND_INSERT, 32'd1);
        queue_req(KIND_INSERT, 32'd5);
        queue_req(KIND_INSERT, -32'sd5);
        queue_req(KIND_INSERT, 32'd100);
        queue_req(KIND_INSERT, -32'sd100);
        queue_req(KIND_INSERT, 32'd7);
        queue_req(KIND_INSERT, 32'd7);
        queue_req(KIND_INSERT, 32'h8000_0001);
        queue_req(KIND_INSERT, 32'h7FFF_FFFE);
        queue_req(KIND_INSERT, 32'd3);
        queue_req(KIND_INSERT, -32'sd3);
        queue_req(KIND_INSERT, 32'd42);
        queue_req(KIND_REMOVE, INT_MAX);
        queue_req(KIND_REMOVE, INT_MIN);
        queue_req(KIND_REMOVE, 32'd0);
        queue_req(KIND_REMOVE, 32'd999);

        // random: phases lean to insert or to remove so the list swings
        // between empty and full, values drawn mostly from a small pool
        insert_pct = 75;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                insert_pct = ((n / PHASE_LEN) % 2 == 0) ? 75 : 25;
                for (int j = 0; j < POOL_SIZE; j++) begin
                    case ($urandom_range(3))
                        0: pool[j] = $urandom;
                        1: pool[j] = $urandom_range(40) - 20;
                        2: pool[j] = $urandom_range(1) ? INT_MAX : INT_MIN;
                        default: pool[j] = $urandom_range(6);
                    endcase
                end
            end
            roll = $urandom_range(99);
            if (roll < 8) begin
                queue_req(kind_t'($urandom_range(1)), $urandom);
            end
            else begin
                kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
                queue_req(kind, pool[$urandom_range(POOL_SIZE - 1)]);
            end
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || cmd_bus.valid || owed_rsps.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("%0d requests, %0d results checked, peak occupancy %0d",
                 reqs_taken, rsps_checked, peak_occupancy);
        $display("inserted %0d, dropped full %0d, removed %0d, not found %0d",
                 status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND]);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // watchdog
    initial begin
        #500us;
        $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sli_pkg.sv
hw/rtl/sli_if.sv
hw/rtl/sli_cell.sv
hw/rtl/sorted_list_insert_remove_unit.sv
test/tb.sv
